### rtl/core/rgb_led_mode_fader_top_assert.svh
// Assertion macros for the RGB LED mode fader.
// Used inside modules that have clk and rst in scope.
`ifndef RGB_LED_MODE_FADER_TOP_ASSERT_SVH
`define RGB_LED_MODE_FADER_TOP_ASSERT_SVH

// Implication checked at every edge outside reset.
`define RLMF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A channel level never moves by more than one step per cycle.
`define RLMF_ASSERT_STEP(lbl, lv) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    !$past(rst) |-> ((lv) == $past(lv) || (lv) == $past(lv) + 8'd1 || \
    (lv) == $past(lv) - 8'd1)) else $error("channel level jumped");

`endif

### rtl/core/rlmf_pkg.sv
// Shared types, codes and color/band functions for the RGB LED mode fader.
// No dependencies.
package rlmf_pkg;

  typedef logic [2:0] idx_t;

  localparam idx_t REG_MODE          = 3'd0;
  localparam idx_t REG_FIXED_COLOR   = 3'd1;
  localparam idx_t REG_ENABLE        = 3'd2;
  localparam idx_t REG_CHANGE_PERIOD = 3'd3;
  localparam idx_t REG_DISABLE_DELAY = 3'd4;

  localparam logic [2:0] MODE_OFF   = 3'd0;
  localparam logic [2:0] MODE_TEMP  = 3'd1;
  localparam logic [2:0] MODE_POWER = 3'd2;
  localparam logic [2:0] MODE_AUTO  = 3'd3;
  localparam logic [2:0] MODE_FIXED = 3'd4;

  localparam logic [3:0] COLOR_OFF         = 4'd0;
  localparam logic [3:0] COLOR_WHITE       = 4'd1;
  localparam logic [3:0] COLOR_LIGHT_BLUE  = 4'd2;
  localparam logic [3:0] COLOR_BLUE        = 4'd3;
  localparam logic [3:0] COLOR_LIGHT_GREEN = 4'd4;
  localparam logic [3:0] COLOR_GREEN       = 4'd5;
  localparam logic [3:0] COLOR_YELLOW      = 4'd6;
  localparam logic [3:0] COLOR_ORANGE      = 4'd7;
  localparam logic [3:0] COLOR_RED         = 4'd8;
  localparam logic [3:0] COLOR_PINK        = 4'd9;

  localparam logic [15:0] CHANGE_PERIOD_RST = 16'd250;
  localparam logic [15:0] DISABLE_DELAY_RST = 16'd100;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  fixed_color;
    logic        enable;
    logic [15:0] change_period;
    logic [15:0] disable_delay;
  } cfg_t;

  typedef struct packed {
    logic       hold;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } target_t;

  // {red, green, blue}; codes above pink read as off
  function automatic logic [23:0] color_rgb(input logic [3:0] code);
    logic [23:0] rgb;
    unique case (code)
      COLOR_WHITE:       rgb = {8'd255, 8'd255, 8'd255};
      COLOR_LIGHT_BLUE:  rgb = {8'd50,  8'd50,  8'd255};
      COLOR_BLUE:        rgb = {8'd0,   8'd0,   8'd255};
      COLOR_LIGHT_GREEN: rgb = {8'd50,  8'd255, 8'd50};
      COLOR_GREEN:       rgb = {8'd0,   8'd255, 8'd0};
      COLOR_YELLOW:      rgb = {8'd255, 8'd255, 8'd0};
      COLOR_ORANGE:      rgb = {8'd255, 8'd50,  8'd0};
      COLOR_RED:         rgb = {8'd255, 8'd0,   8'd0};
      COLOR_PINK:        rgb = {8'd255, 8'd0,   8'd20};
      default:           rgb = 24'd0;
    endcase
    return rgb;
  endfunction

  function automatic logic [3:0] color_by_temp(input logic signed [11:0] t);
    logic [3:0] code;
    priority if (t <= 12'sd300) code = COLOR_LIGHT_BLUE;
    else if (t <= 12'sd320)     code = COLOR_BLUE;
    else if (t <= 12'sd340)     code = COLOR_LIGHT_GREEN;
    else if (t <= 12'sd360)     code = COLOR_GREEN;
    else if (t <= 12'sd380)     code = COLOR_YELLOW;
    else if (t <= 12'sd400)     code = COLOR_ORANGE;
    else                        code = COLOR_RED;
    return code;
  endfunction

  function automatic logic [3:0] color_by_power(input logic [6:0] p);
    logic [3:0] code;
    priority if (p <= 7'd12) code = COLOR_WHITE;
    else if (p <= 7'd25)     code = COLOR_LIGHT_BLUE;
    else if (p <= 7'd38)     code = COLOR_BLUE;
    else if (p <= 7'd51)     code = COLOR_LIGHT_GREEN;
    else if (p <= 7'd64)     code = COLOR_GREEN;
    else if (p <= 7'd77)     code = COLOR_YELLOW;
    else if (p <= 7'd90)     code = COLOR_ORANGE;
    else                     code = COLOR_RED;
    return code;
  endfunction

  function automatic logic [7:0] step_toward(input logic [7:0] now, input logic [7:0] tgt);
    logic [7:0] nxt;
    priority if (now < tgt) nxt = now + 8'd1;
    else if (now > tgt)     nxt = now - 8'd1;
    else                    nxt = now;
    return nxt;
  endfunction

  // 100*level/255 truncated: x/255 == (x + (x >> 8) + 1) >> 8 for x below 2^16 - 1
  function automatic logic [6:0] duty_of(input logic [7:0] lv);
    logic [14:0] prod;
    logic [14:0] sum;
    prod = {7'd0, lv} * 15'd100;
    sum  = prod + (prod >> 8) + 15'd1;
    return sum[14:8];
  endfunction

endpackage

### rtl/core/rlmf_tick_if.sv
// Input channel: one tick item with temperature and heater power.
// No dependencies.
interface rlmf_tick_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] temperature;
  logic [6:0]         power_percent;

  modport source (output valid, temperature, power_percent, input ready);
  modport sink   (input valid, temperature, power_percent, output ready);
endinterface

### rtl/core/rlmf_result_if.sv
// Result channel: faded channel levels, PWM duties and the shown color.
// No dependencies.
interface rlmf_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;
  logic [6:0] red_duty;
  logic [6:0] green_duty;
  logic [6:0] blue_duty;
  logic [3:0] shown_color;

  modport source (output valid, red_level, green_level, blue_level, red_duty, green_duty,
                  blue_duty, shown_color, input ready);
  modport sink   (input valid, red_level, green_level, blue_level, red_duty, green_duty,
                  blue_duty, shown_color, output ready);
endinterface

### rtl/core/rlmf_cfg.sv
// Configuration register file for the RGB LED mode fader.
// Depends on rlmf_pkg.
module rlmf_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  rlmf_pkg::idx_t     cfg_index,
  input  logic [15:0]        cfg_data,
  output rlmf_pkg::cfg_t     cfg,
  output logic               cd_load
);
  import rlmf_pkg::*;

  // every enable write with bit 0 clear reloads the off countdown
  assign cd_load = cfg_we && (cfg_index == REG_ENABLE) && !cfg_data[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode          <= MODE_OFF;
      cfg.fixed_color   <= COLOR_OFF;
      cfg.enable        <= 1'b1;
      cfg.change_period <= CHANGE_PERIOD_RST;
      cfg.disable_delay <= DISABLE_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:          cfg.mode          <= cfg_data[2:0];
        REG_FIXED_COLOR:   cfg.fixed_color   <= cfg_data[3:0];
        REG_ENABLE:        cfg.enable        <= cfg_data[0];
        REG_CHANGE_PERIOD: cfg.change_period <= cfg_data;
        REG_DISABLE_DELAY: cfg.disable_delay <= cfg_data;
        default: ;
      endcase
    end
  end
endmodule

### rtl/core/rlmf_target.sv
// Target color selection: mode decode, auto cycle, off countdown, last color.
// Depends on rlmf_pkg.
module rlmf_target (
  input  logic               clk,
  input  logic               rst,
  input  logic               tick,
  input  rlmf_pkg::cfg_t     cfg,
  input  logic               cd_load,
  input  logic signed [11:0] temperature,
  input  logic [6:0]         power_percent,
  output rlmf_pkg::target_t  tgt,
  output logic [3:0]         shown_next
);
  import rlmf_pkg::*;

  logic [3:0]  cycle_color, cycle_color_next;
  logic [15:0] cycle_ticks, cycle_ticks_next;
  logic [15:0] off_countdown, cd_dec;
  logic [3:0]  last_color;
  logic [15:0] ticks_inc;
  logic [3:0]  code;
  logic [23:0] rgb;
  logic        hold;

  assign cd_dec    = (off_countdown != 16'd0) ? off_countdown - 16'd1 : off_countdown;
  assign ticks_inc = cycle_ticks + 16'd1;

  always_comb begin
    cycle_color_next = cycle_color;
    cycle_ticks_next = cycle_ticks;
    hold             = 1'b0;
    code             = COLOR_OFF;
    if (!cfg.enable) begin
      hold = (cd_dec != 16'd0);
    end else begin
      unique case (cfg.mode)
        MODE_OFF:   code = COLOR_OFF;
        MODE_TEMP:  code = color_by_temp(temperature);
        MODE_POWER: code = color_by_power(power_percent);
        MODE_AUTO: begin
          cycle_ticks_next = ticks_inc;
          if (ticks_inc > cfg.change_period) begin
            cycle_ticks_next = 16'd0;
            cycle_color_next = (cycle_color >= COLOR_PINK) ? COLOR_WHITE
                                                           : cycle_color + 4'd1;
          end
          code = cycle_color_next;
        end
        MODE_FIXED: code = (cfg.fixed_color > COLOR_PINK) ? COLOR_OFF : cfg.fixed_color;
        default:    hold = 1'b1;
      endcase
    end
  end

  assign rgb        = color_rgb(code);
  assign tgt.hold   = hold;
  assign tgt.red    = rgb[23:16];
  assign tgt.green  = rgb[15:8];
  assign tgt.blue   = rgb[7:0];
  assign shown_next = hold ? last_color : code;

  always_ff @(posedge clk) begin
    if (rst) begin
      cycle_color   <= COLOR_WHITE;
      cycle_ticks   <= 16'd0;
      off_countdown <= 16'd0;
      last_color    <= COLOR_OFF;
    end else begin
      if (cd_load) begin
        off_countdown <= cfg.disable_delay;
      end else if (tick && !cfg.enable) begin
        off_countdown <= cd_dec;
      end
      if (tick) begin
        cycle_color <= cycle_color_next;
        cycle_ticks <= cycle_ticks_next;
        last_color  <= shown_next;
      end
    end
  end
endmodule

### rtl/core/rlmf_fader.sv
// One color channel: level register stepping toward its target, and PWM duty.
// Depends on rlmf_pkg.
module rlmf_fader (
  input  logic       clk,
  input  logic       rst,
  input  logic       tick,
  input  logic       hold,
  input  logic [7:0] target,
  output logic [7:0] level,
  output logic [7:0] level_next,
  output logic [6:0] duty_next
);
  import rlmf_pkg::*;

  assign level_next = hold ? level : step_toward(level, target);
  assign duty_next  = duty_of(level_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= 8'd0;
    end else if (tick) begin
      level <= level_next;
    end
  end
endmodule

### rtl/core/rgb_led_mode_fader_top.sv
// RGB LED mode fader: one result item for every tick item.
// tick_in (sink) carries a signed temperature in tenths of a degree and a
// power percentage. result_out (source) returns the three faded channel
// levels, their PWM duties (100*level/255) and the shown color code.
// The cfg port writes mode, fixed_color, enable, change_period and
// disable_delay at index 0..4 on any edge with cfg_we high; other indexes
// are dropped. Write it only while no item is in flight.
// An accepted item waits in the input register; once the result register is
// empty or being emptied, its color, fade step and duties settle into the
// result register, which offers them on result_out until they are taken.
// One item per cycle is sustained while result_out stays ready: the input
// register and the result register each move on as soon as the stage after
// them is empty or being emptied.
// When result_out stalls, the result holds, the input register fills and
// then tick_in.ready drops.
// rst (synchronous) clears the levels to off, restarts the auto cycle at
// white and loads the register reset values.
// Depends on rlmf_pkg, rlmf_tick_if, rlmf_result_if, rlmf_cfg, rlmf_target,
// rlmf_fader and rgb_led_mode_fader_top_assert.svh.
module rgb_led_mode_fader_top (
  input  logic           clk,
  input  logic           rst,
  rlmf_tick_if.sink      tick_in,
  rlmf_result_if.source  result_out,
  input  logic           cfg_we,
  input  rlmf_pkg::idx_t cfg_index,
  input  logic [15:0]    cfg_data
);
  import rlmf_pkg::*;

  cfg_t               cfg;
  logic               cd_load;
  target_t            tgt;
  logic [3:0]         shown_next;

  logic               s1_valid;
  logic signed [11:0] s1_temp;
  logic [6:0]         s1_power;
  logic               tick;

  logic [7:0]         red_lvl, green_lvl, blue_lvl;
  logic [7:0]         red_nx, green_nx, blue_nx;
  logic [6:0]         red_dnx, green_dnx, blue_dnx;

  // advance the input register when the result register frees up
  assign tick          = s1_valid && (!result_out.valid || result_out.ready);
  assign tick_in.ready = !s1_valid || tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick_in.ready) begin
      s1_valid <= tick_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_in.valid && tick_in.ready) begin
      s1_temp  <= tick_in.temperature;
      s1_power <= tick_in.power_percent;
    end
  end

  rlmf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .cd_load   (cd_load)
  );

  rlmf_target u_target (
    .clk           (clk),
    .rst           (rst),
    .tick          (tick),
    .cfg           (cfg),
    .cd_load       (cd_load),
    .temperature   (s1_temp),
    .power_percent (s1_power),
    .tgt           (tgt),
    .shown_next    (shown_next)
  );

  rlmf_fader u_red (
    .clk (clk), .rst (rst), .tick (tick), .hold (tgt.hold), .target (tgt.red),
    .level (red_lvl), .level_next (red_nx), .duty_next (red_dnx)
  );

  rlmf_fader u_green (
    .clk (clk), .rst (rst), .tick (tick), .hold (tgt.hold), .target (tgt.green),
    .level (green_lvl), .level_next (green_nx), .duty_next (green_dnx)
  );

  rlmf_fader u_blue (
    .clk (clk), .rst (rst), .tick (tick), .hold (tgt.hold), .target (tgt.blue),
    .level (blue_lvl), .level_next (blue_nx), .duty_next (blue_dnx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (tick) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      result_out.red_level   <= red_nx;
      result_out.green_level <= green_nx;
      result_out.blue_level  <= blue_nx;
      result_out.red_duty    <= red_dnx;
      result_out.green_duty  <= green_dnx;
      result_out.blue_duty   <= blue_dnx;
      result_out.shown_color <= shown_next;
    end
  end

  `include "rgb_led_mode_fader_top_assert.svh"

  `RLMF_ASSERT_STEP(a_red_step, red_lvl)
  `RLMF_ASSERT_STEP(a_green_step, green_lvl)
  `RLMF_ASSERT_STEP(a_blue_step, blue_lvl)
  `RLMF_ASSERT_IMPL(a_level_matches_result, result_out.valid, result_out.red_level == red_lvl && result_out.blue_level == blue_lvl, "result register out of step with level")
  `RLMF_ASSERT_IMPL(a_shown_color_range, result_out.valid, result_out.shown_color <= COLOR_PINK && result_out.red_duty <= 7'd100, "result out of range")

endmodule

### verif/rgb_led_mode_fader_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for rgb_led_mode_fader_top: a directed table, then random register
// phases with tick bursts; results are held to table values or a local fader predictor.
// Depends on rlmf_pkg, rlmf_tick_if, rlmf_result_if and the fader RTL.
module rgb_led_mode_fader_top_tb;
  import rlmf_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_TICKS  = 1600;
  localparam int GAP_PCT       = 9;
  localparam int PRINT_LIMIT   = 40;

  localparam idx_t       REG_SPARE_LO = 3'd5;
  localparam idx_t       REG_SPARE_HI = 3'd7;
  localparam logic [2:0] MODE_BAD_LO  = 3'd5;
  localparam logic [2:0] MODE_BAD_HI  = 3'd7;
  localparam logic [3:0] COLOR_BAD_HI = 4'd15;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] red_duty;
    logic [6:0] green_duty;
    logic [6:0] blue_duty;
    logic [3:0] color;
  } led_out_t;

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [3:0]  cycle_color;
    logic [15:0] cycle_ticks;
    logic [15:0] off_countdown;
    logic [3:0]  last_color;
  } fade_state_t;

  typedef enum {ROW_WRITE, ROW_TICK} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    idx_t               index;
    logic [15:0]        data;
    logic signed [11:0] temp;
    logic [6:0]         power;
    bit                 known;
    led_out_t           want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  idx_t        cfg_index;
  logic [15:0] cfg_data;

  rlmf_tick_if   tick_ch ();
  rlmf_result_if res_ch ();

  rgb_led_mode_fader_top dut (
    .clk        (clk),
    .rst        (rst),
    .tick_in    (tick_ch),
    .result_out (res_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  cfg_t        shadow_cfg;
  fade_state_t fade;
  led_out_t    expected_leds[$];
  script_row_t script_rows[$];

  int errors          = 0;
  int ticks_sent      = 0;
  int results_checked = 0;
  int reg_writes      = 0;
  int idle_cycles     = 0;
  int disabled_ticks  = 0;
  int mode_ticks[8];
  bit gaps_on         = 1'b1;

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic [23:0] color_levels(logic [3:0] code);
    case (code)
      COLOR_WHITE:       return {8'd255, 8'd255, 8'd255};
      COLOR_LIGHT_BLUE:  return {8'd50,  8'd50,  8'd255};
      COLOR_BLUE:        return {8'd0,   8'd0,   8'd255};
      COLOR_LIGHT_GREEN: return {8'd50,  8'd255, 8'd50};
      COLOR_GREEN:       return {8'd0,   8'd255, 8'd0};
      COLOR_YELLOW:      return {8'd255, 8'd255, 8'd0};
      COLOR_ORANGE:      return {8'd255, 8'd50,  8'd0};
      COLOR_RED:         return {8'd255, 8'd0,   8'd0};
      COLOR_PINK:        return {8'd255, 8'd0,   8'd20};
      default:           return 24'd0;
    endcase
  endfunction

  function automatic logic [3:0] temp_color(logic signed [11:0] t);
    if (t <= 12'sd300) return COLOR_LIGHT_BLUE;
    if (t <= 12'sd320) return COLOR_BLUE;
    if (t <= 12'sd340) return COLOR_LIGHT_GREEN;
    if (t <= 12'sd360) return COLOR_GREEN;
    if (t <= 12'sd380) return COLOR_YELLOW;
    if (t <= 12'sd400) return COLOR_ORANGE;
    return COLOR_RED;
  endfunction

  function automatic logic [3:0] power_color(logic [6:0] p);
    if (p <= 7'd12) return COLOR_WHITE;
    if (p <= 7'd25) return COLOR_LIGHT_BLUE;
    if (p <= 7'd38) return COLOR_BLUE;
    if (p <= 7'd51) return COLOR_LIGHT_GREEN;
    if (p <= 7'd64) return COLOR_GREEN;
    if (p <= 7'd77) return COLOR_YELLOW;
    if (p <= 7'd90) return COLOR_ORANGE;
    return COLOR_RED;
  endfunction

  function automatic logic [7:0] fade_step(logic [7:0] now, logic [7:0] goal);
    if (now < goal) return now + 8'd1;
    if (now > goal) return now - 8'd1;
    return now;
  endfunction

  function automatic logic [6:0] duty_pct(logic [7:0] lv);
    int pct;
    pct = int'(lv) * 100 / 255;
    return 7'(pct);
  endfunction

  // move one step toward the color; codes above pink count as off
  function automatic void aim_at(logic [3:0] code);
    logic [23:0] rgb;
    if (code > COLOR_PINK) code = COLOR_OFF;
    rgb = color_levels(code);
    fade.red        = fade_step(fade.red,   rgb[23:16]);
    fade.green      = fade_step(fade.green, rgb[15:8]);
    fade.blue       = fade_step(fade.blue,  rgb[7:0]);
    fade.last_color = code;
  endfunction

  function automatic led_out_t predict_tick(logic signed [11:0] t, logic [6:0] p);
    led_out_t o;
    if (!shadow_cfg.enable) begin
      if (fade.off_countdown != 16'd0) fade.off_countdown = fade.off_countdown - 16'd1;
      if (fade.off_countdown == 16'd0) aim_at(COLOR_OFF);
    end else begin
      case (shadow_cfg.mode)
        MODE_OFF:   aim_at(COLOR_OFF);
        MODE_TEMP:  aim_at(temp_color(t));
        MODE_POWER: aim_at(power_color(p));
        MODE_AUTO: begin
          fade.cycle_ticks = fade.cycle_ticks + 16'd1;
          if (fade.cycle_ticks > shadow_cfg.change_period) begin
            fade.cycle_color = (fade.cycle_color >= COLOR_PINK) ? COLOR_WHITE
                                                                 : fade.cycle_color + 4'd1;
            fade.cycle_ticks = 16'd0;
          end
          aim_at(fade.cycle_color);
        end
        MODE_FIXED: aim_at(shadow_cfg.fixed_color);
        default: ;
      endcase
    end
    o.red        = fade.red;
    o.green      = fade.green;
    o.blue       = fade.blue;
    o.red_duty   = duty_pct(fade.red);
    o.green_duty = duty_pct(fade.green);
    o.blue_duty  = duty_pct(fade.blue);
    o.color      = fade.last_color;
    return o;
  endfunction

  function automatic void apply_write(idx_t idx, logic [15:0] d);
    case (idx)
      REG_MODE:          shadow_cfg.mode = d[2:0];
      REG_FIXED_COLOR:   shadow_cfg.fixed_color = d[3:0];
      REG_ENABLE: begin
        shadow_cfg.enable = d[0];
        if (!d[0]) fade.off_countdown = shadow_cfg.disable_delay;
      end
      REG_CHANGE_PERIOD: shadow_cfg.change_period = d;
      REG_DISABLE_DELAY: shadow_cfg.disable_delay = d;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic report_mismatch(string what, int got, int want);
    if (errors < PRINT_LIMIT)
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic write_reg(idx_t idx, logic [15:0] d);
    tick_ch.valid <= 1'b0;
    while (expected_leds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_write(idx, d);
    reg_writes++;
  endtask

  task automatic send_tick(logic signed [11:0] t, logic [6:0] p, bit known, led_out_t want);
    led_out_t predicted;
    while (gaps_on && $urandom_range(99) < GAP_PCT) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid         <= 1'b1;
    tick_ch.temperature   <= t;
    tick_ch.power_percent <= p;
    do @(posedge clk); while (!tick_ch.ready);
    if (!shadow_cfg.enable) disabled_ticks++;
    else mode_ticks[shadow_cfg.mode]++;
    predicted = predict_tick(t, p);
    expected_leds.push_back(known ? want : predicted);
    ticks_sent++;
  endtask

  function automatic void add_write(idx_t idx, logic [15:0] d);
    script_row_t row;
    row.kind  = ROW_WRITE;
    row.index = idx;
    row.data  = d;
    row.temp  = '0;
    row.power = '0;
    row.known = 1'b0;
    row.want  = '0;
    script_rows.push_back(row);
  endfunction

  function automatic void add_tick(logic signed [11:0] t, logic [6:0] p, bit known = 1'b0,
                                   led_out_t want = '0);
    script_row_t row;
    row.kind  = ROW_TICK;
    row.index = REG_MODE;
    row.data  = '0;
    row.temp  = t;
    row.power = p;
    row.known = known;
    row.want  = want;
    script_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------- result side

  always @(posedge clk) begin
    res_ch.ready <= !(gaps_on && $urandom_range(99) < GAP_PCT);
  end

  always @(posedge clk) begin : result_check
    led_out_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_leds.size() == 0) begin
        report_mismatch("result with no tick pending, red_level", res_ch.red_level, -1);
      end else begin
        want = expected_leds.pop_front();
        results_checked++;
        if (res_ch.red_level !== want.red)
          report_mismatch("red_level", res_ch.red_level, want.red);
        if (res_ch.green_level !== want.green)
          report_mismatch("green_level", res_ch.green_level, want.green);
        if (res_ch.blue_level !== want.blue)
          report_mismatch("blue_level", res_ch.blue_level, want.blue);
        if (res_ch.red_duty !== want.red_duty)
          report_mismatch("red_duty", res_ch.red_duty, want.red_duty);
        if (res_ch.green_duty !== want.green_duty)
          report_mismatch("green_duty", res_ch.green_duty, want.green_duty);
        if (res_ch.blue_duty !== want.blue_duty)
          report_mismatch("blue_duty", res_ch.blue_duty, want.blue_duty);
        if (res_ch.shown_color !== want.color)
          report_mismatch("shown_color", res_ch.shown_color, want.color);
      end
    end
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
                 STALL_LIMIT, expected_leds.size());
        $display("rgb_led_mode_fader_top_tb: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    logic signed [11:0] t;
    logic [6:0]         p;
    logic [2:0]         md;
    logic [3:0]         fc;
    logic [15:0]        val;
    int                 random_ticks;
    int                 burst;
    int                 roll;

    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = REG_MODE;
    cfg_data              = '0;
    tick_ch.valid         = 1'b0;
    tick_ch.temperature   = '0;
    tick_ch.power_percent = '0;
    foreach (mode_ticks[i]) mode_ticks[i] = 0;

    shadow_cfg = '{MODE_OFF, COLOR_OFF, 1'b1, CHANGE_PERIOD_RST, DISABLE_DELAY_RST};
    fade       = '{8'd0, 8'd0, 8'd0, COLOR_WHITE, 16'd0, 16'd0, COLOR_OFF};

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // off after reset, then white one step up, then an out-of-range fixed code
    add_tick(12'sd0, 7'd0, 1'b1, '{8'd0, 8'd0, 8'd0, 7'd0, 7'd0, 7'd0, COLOR_OFF});
    add_write(REG_MODE, {13'd0, MODE_FIXED});
    add_write(REG_FIXED_COLOR, {12'd0, COLOR_WHITE});
    add_tick(12'sd0, 7'd0, 1'b1, '{8'd1, 8'd1, 8'd1, 7'd0, 7'd0, 7'd0, COLOR_WHITE});
    add_write(REG_FIXED_COLOR, {12'hFFF, COLOR_BAD_HI});
    add_tick(12'sd0, 7'd0, 1'b1, '{8'd0, 8'd0, 8'd0, 7'd0, 7'd0, 7'd0, COLOR_OFF});
    // temperature band edges and field extremes
    add_write(REG_MODE, {13'd0, MODE_TEMP});
    add_tick(-12'sd2048, 7'd127);
    add_tick(12'sd300, 7'd0);
    add_tick(12'sd301, 7'd85);
    add_tick(12'sd340, 7'd42);
    add_tick(12'sd381, 7'd0);
    add_tick(12'sd401, 7'd127);
    add_tick(12'sd2047, 7'd0);
    // power band edges
    add_write(REG_MODE, {13'd0, MODE_POWER});
    add_tick(-12'sd1, 7'd12);
    add_tick(12'sd1365, 7'd13);
    add_tick(-12'sd1366, 7'd38);
    add_tick(12'sd0, 7'd64);
    add_tick(12'sd0, 7'd90);
    add_tick(12'sd0, 7'd91);
    add_tick(12'sd0, 7'd127);
    // auto cycle advancing on every tick
    add_write(REG_CHANGE_PERIOD, 16'd0);
    add_write(REG_MODE, {13'd0, MODE_AUTO});
    add_tick(12'sd0, 7'd0);
    add_tick(12'sd0, 7'd0);
    add_tick(12'sd0, 7'd0);
    // undefined mode holds; writes to unused indexes are dropped
    add_write(REG_MODE, {13'h1FFF, MODE_BAD_HI});
    add_write(REG_SPARE_LO, 16'hFFFF);
    add_write(REG_SPARE_HI, 16'h0004);
    add_tick(12'sd0, 7'd0);
    // disable: countdown holds, then fade toward off
    add_write(REG_MODE, {13'd0, MODE_FIXED});
    add_write(REG_DISABLE_DELAY, 16'd2);
    add_write(REG_ENABLE, 16'd0);
    add_tick(12'sd0, 7'd0);
    add_tick(12'sd0, 7'd0);
    add_tick(12'sd0, 7'd0);
    add_write(REG_ENABLE, 16'hFFFF);
    add_write(REG_CHANGE_PERIOD, 16'hFFFF);
    add_write(REG_DISABLE_DELAY, 16'hFFFF);
    add_write(REG_ENABLE, 16'hFFFE);
    add_tick(12'sd0, 7'd0);
    add_write(REG_ENABLE, 16'd1);

    foreach (script_rows[i]) begin
      if (script_rows[i].kind == ROW_WRITE)
        write_reg(script_rows[i].index, script_rows[i].data);
      else
        send_tick(script_rows[i].temp, script_rows[i].power, script_rows[i].known,
                  script_rows[i].want);
    end

    random_ticks = 0;
    while (random_ticks < RANDOM_TICKS) begin
      // hold both sides busy through the middle of the run
      gaps_on = !(random_ticks >= 600 && random_ticks < 1000);

      roll = $urandom_range(99);
      if (roll < 8)       md = MODE_OFF;
      else if (roll < 28) md = MODE_TEMP;
      else if (roll < 48) md = MODE_POWER;
      else if (roll < 70) md = MODE_AUTO;
      else if (roll < 92) md = MODE_FIXED;
      else                md = 3'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
      write_reg(REG_MODE, {13'($urandom), md});

      if ($urandom_range(1) == 0) begin
        fc = ($urandom_range(3) == 0) ? 4'($urandom_range(0, 15))
                                      : 4'($urandom_range(COLOR_OFF, COLOR_PINK));
        write_reg(REG_FIXED_COLOR, {12'($urandom), fc});
      end

      if ($urandom_range(1) == 0) begin
        roll = $urandom_range(99);
        if (roll < 60)      val = 16'($urandom_range(0, 40));
        else if (roll < 80) val = 16'($urandom_range(0, 400));
        else if (roll < 90) val = 16'hFFFF;
        else if (roll < 95) val = 16'd0;
        else                val = 16'($urandom);
        write_reg(REG_CHANGE_PERIOD, val);
      end

      if ($urandom_range(1) == 0) begin
        roll = $urandom_range(99);
        if (roll < 75)      val = 16'($urandom_range(0, 30));
        else if (roll < 85) val = 16'hFFFF;
        else                val = 16'($urandom);
        write_reg(REG_DISABLE_DELAY, val);
      end

      if (!shadow_cfg.enable && $urandom_range(3) != 0)
        write_reg(REG_ENABLE, {15'($urandom), 1'b1});
      else if ($urandom_range(4) == 0)
        write_reg(REG_ENABLE, {15'($urandom), 1'b0});
      else if ($urandom_range(3) == 0)
        write_reg(REG_ENABLE, {15'($urandom), 1'b1});

      if ($urandom_range(9) == 0)
        write_reg(idx_t'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom));

      // long bursts let the levels run all the way to the ends of the range
      burst = ($urandom_range(99) < 15) ? $urandom_range(256, 320) : $urandom_range(8, 80);
      repeat (burst) begin
        roll = $urandom_range(99);
        if (roll < 60)      t = 12'($urandom_range(280, 420));
        else if (roll < 80) t = 12'($urandom);
        else                t = 12'(int'($urandom_range(0, 2500)) - 1000);
        p = ($urandom_range(99) < 85) ? 7'($urandom_range(0, 100)) : 7'($urandom);
        send_tick(t, p, 1'b0, '0);
        random_ticks++;
      end
    end

    gaps_on = 1'b1;
    tick_ch.valid <= 1'b0;
    while (expected_leds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d ticks, %0d results checked, %0d register writes", ticks_sent,
             results_checked, reg_writes);
    $display("ticks by mode: off %0d, temp %0d, power %0d, auto %0d, fixed %0d, %s %0d, %s %0d",
             mode_ticks[MODE_OFF], mode_ticks[MODE_TEMP], mode_ticks[MODE_POWER],
             mode_ticks[MODE_AUTO], mode_ticks[MODE_FIXED], "undefined",
             mode_ticks[5] + mode_ticks[6] + mode_ticks[7], "disabled", disabled_ticks);
    if (errors == 0) begin
      $display("rgb_led_mode_fader_top_tb: PASS");
    end else begin
      $display("rgb_led_mode_fader_top_tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/rlmf_pkg.sv
rtl/core/rlmf_tick_if.sv
rtl/core/rlmf_result_if.sv
rtl/core/rlmf_cfg.sv
rtl/core/rlmf_target.sv
rtl/core/rlmf_fader.sv
rtl/core/rgb_led_mode_fader_top.sv
verif/rgb_led_mode_fader_top_tb.sv
